// ----- hw/rtl/bf2x2_pkg.sv -----
// Shared types and constants of the 2x2 box filter stream.
// No dependencies; imported by the interfaces and every module but bf2x2_ram.
package bf2x2_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MIN_SIZE  = 2;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Edge flags of one pixel position, worked out when the word is taken in.
  typedef struct packed {
    logic last_row;
    logic last_col;
  } pos_flags_t;

endpackage

// ----- hw/rtl/bf2x2_in_if.sv -----
// Input pixel channel: valid/ready plus one packed pixel word.
// Depends on bf2x2_pkg.
interface bf2x2_in_if import bf2x2_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ----- hw/rtl/bf2x2_out_if.sv -----
// Result channel: valid/ready plus filtered pixel and its position tags.
// Depends on bf2x2_pkg.
interface bf2x2_out_if import bf2x2_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic               last_of_run;
  logic               end_of_frame;

  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output last_of_run, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input last_of_run, input end_of_frame, output ready);
endinterface

// ----- hw/rtl/bf2x2_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on bf2x2_pkg.
interface bf2x2_cfg_if import bf2x2_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bf2x2_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on a same-address write. No dependencies.
module bf2x2_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bf2x2_pos.sv -----
// Frame size registers and raster position counters.
// Depends on bf2x2_pkg and bf2x2_cfg_if.
module bf2x2_pos import bf2x2_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bf2x2_cfg_if.sink                     cfg_i,
  input  logic                          advance_i,
  output logic [$clog2(MAX_WIDTH)-1:0]  x_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] y_o,
  output pos_flags_t                    flags_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SZ_W  = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned SZ_H  = $clog2(MAX_HEIGHT) + 1;
  localparam int unsigned SZ_M  = (SZ_W > SZ_H) ? SZ_W : SZ_H;
  localparam int unsigned CMPW  = (SZ_M > CFG_W) ? SZ_M : CFG_W;

  localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] MAX_H_C = CMPW'(MAX_HEIGHT);
  localparam logic [CMPW-1:0] MIN_C   = CMPW'(MIN_SIZE);

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    x_q, x_d;
  logic [RW-1:0]    y_q, y_d;
  logic [CMPW-1:0]  width_ext, height_ext, width_eff, height_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_SIZE_RESET;
      height_q <= CFG_SIZE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FRAME_WIDTH:  width_q  <= cfg_i.data;
        REG_FRAME_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // out-of-range sizes saturate to [2, MAX]
  always_comb begin
    width_ext  = CMPW'(width_q);
    height_ext = CMPW'(height_q);
    if (width_ext < MIN_C)        width_eff = MIN_C;
    else if (width_ext > MAX_W_C) width_eff = MAX_W_C;
    else                          width_eff = width_ext;
    if (height_ext < MIN_C)        height_eff = MIN_C;
    else if (height_ext > MAX_H_C) height_eff = MAX_H_C;
    else                           height_eff = height_ext;
  end

  // ">=" so a counter past a shrunken size still wraps
  assign flags_o.last_col = CMPW'(x_q) >= (width_eff - CMPW'(1));
  assign flags_o.last_row = CMPW'(y_q) >= (height_eff - CMPW'(1));

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (advance_i) begin
      if (flags_o.last_col) begin
        x_d = '0;
        y_d = flags_o.last_row ? '0 : y_q + RW'(1);
      end else begin
        x_d = x_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ----- hw/rtl/bf2x2_emit.sv -----
// Filter arithmetic, left-neighbor registers and the output register.
// Splits a last-row word into two results. Depends on bf2x2_pkg, bf2x2_out_if.
module bf2x2_emit import bf2x2_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  logic [PIX_W-1:0]              s1_pix_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  s1_x_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] s1_y_i,
  input  pos_flags_t                    s1_flags_i,
  input  logic [PIX_W-1:0]              above_i,
  output logic                          done_o,
  bf2x2_out_if.source                   out_o
);

  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic               phase_q, phase_d;
  logic [PIX_W-1:0]   left_above_q, left_current_q;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   out_pix_q, out_pix_d;
  logic [COORD_W-1:0] out_col_q, out_col_d;
  logic [COORD_W-1:0] out_row_q, out_row_d;
  logic               out_last_q, out_last_d;
  logic               out_eof_q, out_eof_d;

  logic             has_above, needs_out, emit_second, is_last, load;
  logic [PIX_W-1:0] box_sum;

  assign has_above   = s1_y_i != '0;
  assign needs_out   = has_above | s1_flags_i.last_row;
  assign emit_second = phase_q | !has_above;
  assign is_last     = emit_second | !s1_flags_i.last_row;
  assign load        = s1_valid_i & needs_out & (!out_valid_q | out_o.ready);
  assign done_o      = s1_valid_i & (!needs_out | (load & is_last));

  // whole-word shifts: the sum of four quarters fits in 32 bits
  assign box_sum = (above_i >> 2) + (left_above_q >> 2)
                 + (s1_pix_i >> 2) + (left_current_q >> 2);

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_last_d  = out_last_q;
    out_eof_d   = out_eof_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      phase_d     = !is_last;
      out_col_d   = COORD_W'(s1_x_i);
      if (emit_second) begin
        // last row passes through
        out_pix_d  = s1_pix_i;
        out_row_d  = COORD_W'(s1_y_i);
        out_last_d = 1'b1;
        out_eof_d  = s1_flags_i.last_col;
      end else begin
        out_pix_d  = (s1_x_i == '0) ? above_i : box_sum;
        out_row_d  = COORD_W'(s1_y_i - RW'(1));
        out_last_d = !s1_flags_i.last_row;
        out_eof_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      left_above_q   <= '0;
      left_current_q <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (done_o) begin
        left_above_q   <= above_i;
        left_current_q <= s1_pix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_last_q <= out_last_d;
    out_eof_q  <= out_eof_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_out    = out_pix_q;
  assign out_o.out_column   = out_col_q;
  assign out_o.out_row      = out_row_q;
  assign out_o.last_of_run  = out_last_q;
  assign out_o.end_of_frame = out_eof_q;

endmodule

// ----- hw/rtl/box_filter_2x2_stream.sv -----
// Top level of the 2x2 box filter stream: input register, row store RAM,
// position counters and result stage. Depends on bf2x2_pkg, the three
// interfaces, bf2x2_ram, bf2x2_pos and bf2x2_emit.
//
// Takes one frame of packed 32-bit pixels in raster order and returns the
// next frame: each pixel of column 1 and up, above the last row, becomes
// (p>>2)+(left>>2)+(below>>2)+(below_left>>2), shifted on the whole word.
// Column 0 and the last row pass through. Row y comes out while row y+1 goes
// in, so the first row yields no result and each word of the last row yields
// two (the pixel above it, then itself). Rate: one input word per clock
// outside the last row while the output is ready; a last-row word stays in
// the input register until both its results enter the single output
// register, one result per clock while the output is ready. A result passes
// the input register, where the row store is read, then the output register.
// The row store, a MAX_WIDTH x 32 RAM, is read and written at the same column
// in the accept cycle (read-first); it is not cleared after reset and needs
// no sweep, as the first row fills it before any read is used. The user must
// write frame size registers (index 0 width, 1 height) only while the block
// is idle; the block does not enforce it. Sizes outside [2, MAX] saturate.
module box_filter_2x2_stream import bf2x2_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bf2x2_in_if.sink    in_i,
  bf2x2_out_if.source out_o,
  bf2x2_cfg_if.sink   cfg_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]    pos_x;
  logic [RW-1:0]    pos_y;
  pos_flags_t       pos_flags;
  logic             in_accept;
  logic             s1_done;
  logic [PIX_W-1:0] above;

  // input register
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_x_q;
  logic [RW-1:0]    s1_y_q;
  pos_flags_t       s1_flags_q;

  // a new word enters as the held one finishes
  assign in_i.ready = !s1_valid_q | s1_done;
  assign in_accept  = in_i.valid & in_i.ready;

  bf2x2_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .advance_i (in_accept),
    .x_o       (pos_x),
    .y_o       (pos_y),
    .flags_o   (pos_flags)
  );

  // row store: previous row's word at this column comes back next cycle,
  // and holds until the next accept since reads happen only on accept
  bf2x2_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (pos_x),
    .wdata_i (in_i.pixel_in),
    .re_i    (in_accept),
    .raddr_i (pos_x),
    .rdata_o (above)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_done) s1_valid_d = 1'b0;
    if (in_accept) s1_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= in_i.pixel_in;
      s1_x_q     <= pos_x;
      s1_y_q     <= pos_y;
      s1_flags_q <= pos_flags;
    end
  end

  bf2x2_emit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_pix_i   (s1_pix_q),
    .s1_x_i     (s1_x_q),
    .s1_y_i     (s1_y_q),
    .s1_flags_i (s1_flags_q),
    .above_i    (above),
    .done_o     (s1_done),
    .out_o      (out_o)
  );

  // an accepted word is always held in the input register next cycle
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted word not held in input register");

  // a word not yet finished stays put
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_done |=> s1_valid_q && $stable(s1_pix_q) && $stable(s1_x_q)
      && $stable(s1_y_q))
    else $error("unfinished word changed in input register");

  // the frame's closing result is always the final one of its word
  a_eof_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_of_frame |-> out_o.last_of_run)
    else $error("end of frame without last of run");

endmodule
